/* rtl/core/flat_face_normal_engine_core_macros.svh */
// Assertion macros for the flat face normal engine core.
`ifndef FLAT_FACE_NORMAL_ENGINE_CORE_MACROS_SVH
`define FLAT_FACE_NORMAL_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FFNE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FFNE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ffne_pkg.sv */
// Shared types and constants of the flat face normal engine.
`timescale 1ns / 1ps
package ffne_pkg;

  localparam int VertexDepthDef = 1024;
  localparam int IdxW           = 10;
  localparam int PosW           = 16;
  localparam int VtxW           = 3 * PosW;
  localparam int EdgeW          = PosW + 1;
  localparam int CrossW         = 35;
  localparam int MagW           = CrossW - 1;
  localparam int HalfW          = MagW / 2;
  localparam int SumW           = 2 * MagW;
  localparam int RootW          = MagW;
  localparam int RemW           = RootW + 4;
  localparam int MulW           = HalfW + 1;
  localparam int ProdW          = 2 * MulW;
  localparam int NormW          = 16;
  localparam int QuotW          = 15;
  localparam int UnitVal        = 16384;
  localparam int UnitShift      = 14;
  localparam int RootSteps      = SumW / 2;
  localparam int DivSteps       = QuotW;
  localparam int CntW           = 6;
  localparam int DataW          = 80;

  typedef enum logic {
    CMD_VERTEX   = 1'b0,
    CMD_TRIANGLE = 1'b1
  } ffne_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_RDC,
    ST_EDGE,
    ST_XMUL,
    ST_SQMUL,
    ST_ROOT,
    ST_LEN,
    ST_DIV,
    ST_DONE
  } ffne_state_e;

  typedef enum logic [1:0] {
    PART_HH,
    PART_HL,
    PART_LL
  } ffne_part_e;

  typedef enum logic {
    RD_SQRT,
    RD_DIV
  } ffne_rd_mode_e;

  typedef struct packed {
    logic          load;
    logic          step;
    ffne_rd_mode_e mode;
  } ffne_rd_ctl_t;

endpackage

/* rtl/core/ffne_vstore.sv */
// Vertex position memory, one write port and one registered read port.
`timescale 1ns / 1ps
module ffne_vstore #(
  parameter int DEPTH = ffne_pkg::VertexDepthDef,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [ffne_pkg::VtxW-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [ffne_pkg::VtxW-1:0] rdata_o
);
  import ffne_pkg::*;

  logic [VtxW-1:0] mem_q [DEPTH];
  logic [VtxW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ffne_mul.sv */
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module ffne_mul (
  input  logic                              clk_i,
  input  logic signed [ffne_pkg::MulW-1:0]  a_i,
  input  logic signed [ffne_pkg::MulW-1:0]  b_i,
  output logic signed [ffne_pkg::ProdW-1:0] p_o
);
  import ffne_pkg::*;

  logic signed [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

/* rtl/core/ffne_rdunit.sv */
// Shared restoring unit: square root two bits a step, division one bit a step.
`timescale 1ns / 1ps
module ffne_rdunit (
  input  logic                          clk_i,
  input  ffne_pkg::ffne_rd_ctl_t        ctl_i,
  input  logic [ffne_pkg::RemW-1:0]     load_rem_i,
  input  logic [1:0]                    src_i,
  input  logic [ffne_pkg::RootW-1:0]    divisor_i,
  output logic [ffne_pkg::RootW-1:0]    res_o
);
  import ffne_pkg::*;

  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] res_q, res_d;
  logic [RemW-1:0]  shifted;
  logic [RemW-1:0]  trial;
  logic [RemW:0]    diff;
  logic             ge;

  always_comb begin
    if (ctl_i.mode == RD_SQRT) begin
      shifted = {rem_q[RemW-3:0], src_i};
      trial   = RemW'({res_q, 2'b01});
    end else begin
      shifted = {rem_q[RemW-2:0], src_i[0]};
      trial   = RemW'(divisor_i);
    end
    diff = {1'b0, shifted} - {1'b0, trial};
    ge   = ~diff[RemW];
  end

  always_comb begin
    rem_d = rem_q;
    res_d = res_q;
    if (ctl_i.load) begin
      rem_d = load_rem_i;
      res_d = '0;
    end else if (ctl_i.step) begin
      rem_d = ge ? diff[RemW-1:0] : shifted;
      res_d = {res_q[RootW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

/* rtl/core/flat_face_normal_engine_core.sv */
// Top level of the flat face normal engine: sequencer and datapath.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  s_axis   | in  | index_a, index_b, index_c, pos_x, pos_y, pos_z | cmd
//  m_axis   | out | normal_x, normal_y, normal_z, corner_a/b/c   | degenerate
//
//  A triangle takes 34 square root steps and, unless the cross product is zero, three
//  times 15 division steps on the shared subtractor, plus 6 cross and 9 square
//  products on the shared multiplier. s_axis_tready is low while a triangle is in work.
//  A finished result waits in the output register while the next item is taken.
//  Reset clears control only; the vertex memory holds garbage until written.
`timescale 1ns / 1ps
`include "flat_face_normal_engine_core_macros.svh"
module flat_face_normal_engine_core #(
  parameter int VERTEX_DEPTH = ffne_pkg::VertexDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // index_a[9:0], index_b[19:10], index_c[29:20], pos_x[45:30], pos_y[61:46],
  // pos_z[77:62], zero[79:78]
  input  logic [ffne_pkg::DataW-1:0] s_axis_tdata,
  // cmd[0]
  input  logic [0:0]                 s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // normal_x[15:0], normal_y[31:16], normal_z[47:32], corner_a[57:48],
  // corner_b[67:58], corner_c[77:68], zero[79:78]
  output logic [ffne_pkg::DataW-1:0] m_axis_tdata,
  // degenerate[0]
  output logic [0:0]                 m_axis_tuser
);
  import ffne_pkg::*;

  localparam int AddrW = $clog2(VERTEX_DEPTH);

  ffne_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q;
  logic [1:0]      comp_q;
  ffne_part_e      part_q, part_d1_q;

  logic [IdxW-1:0] idx_q [3];
  logic            ok_q  [3];

  logic signed [PosW-1:0]   pa_q [3];
  logic signed [PosW-1:0]   pb_q [3];
  logic signed [EdgeW-1:0]  e1_q [3];
  logic signed [EdgeW-1:0]  e2_q [3];
  logic signed [CrossW-1:0] cr_q [3];
  logic [SumW-1:0]          s_q;
  logic [RootW-1:0]         len_q;
  logic [NormW-1:0]         norm_q [3];
  logic                     deg_q;

  logic             out_valid_q;
  logic [DataW-1:0] out_data_q;
  logic             out_user_q;

  logic [IdxW-1:0] in_idx [3];
  logic [VtxW-1:0] in_pos;
  logic            in_cmd;
  logic            in_ok  [3];
  logic            s_fire;
  logic            out_free;

  logic            vs_we;
  logic [AddrW-1:0] vs_raddr;
  logic [VtxW-1:0] vs_rdata;
  logic signed [PosW-1:0] rd_pos [3];

  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;

  ffne_rd_ctl_t     rd_ctl;
  logic [RemW-1:0]  rd_load_rem;
  logic [1:0]       rd_src;
  logic [RootW-1:0] rd_res;

  logic signed [CrossW-1:0] cr_sel;
  logic signed [CrossW-1:0] cr_neg;
  logic [MagW-1:0]          mag_w;
  logic [HalfW-1:0]         mag_hi, mag_lo;
  logic [2:0]               xidx;
  logic [SumW-1:0]          sq_term;
  logic [QuotW-1:0]         quot;
  logic [NormW-1:0]         quot_ext;

  always_comb begin
    in_cmd    = s_axis_tuser[0];
    in_idx[0] = s_axis_tdata[9:0];
    in_idx[1] = s_axis_tdata[19:10];
    in_idx[2] = s_axis_tdata[29:20];
    in_pos    = s_axis_tdata[77:30];
    for (int i = 0; i < 3; i++) begin
      in_ok[i] = (32'(in_idx[i]) < 32'(VERTEX_DEPTH));
    end
    s_fire   = s_axis_tvalid && s_axis_tready;
    out_free = !out_valid_q || m_axis_tready;
    for (int i = 0; i < 3; i++) begin
      rd_pos[i] = $signed(vs_rdata[PosW*i +: PosW]);
    end
  end

  always_comb begin
    cr_sel   = cr_q[comp_q];
    cr_neg   = -cr_sel;
    mag_w    = cr_sel[CrossW-1] ? cr_neg[MagW-1:0] : cr_sel[MagW-1:0];
    mag_hi   = mag_w[MagW-1:HalfW];
    mag_lo   = mag_w[HalfW-1:0];
    xidx     = 3'(cnt_q - CntW'(1));
    quot     = (rd_res > RootW'(UnitVal)) ? QuotW'(UnitVal) : rd_res[QuotW-1:0];
    quot_ext = {1'b0, quot};
    case (part_d1_q)
      PART_HH: sq_term = SumW'(mul_p[SumW/2-1:0]) << (2 * HalfW);
      PART_HL: sq_term = SumW'(mul_p[SumW/2-1:0]) << (HalfW + 1);
      PART_LL: sq_term = SumW'(mul_p[SumW/2-1:0]);
      default: sq_term = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && (in_cmd == CMD_TRIANGLE)) state_d = ST_RDA;
      end
      ST_RDA:  state_d = ST_RDB;
      ST_RDB:  state_d = ST_RDC;
      ST_RDC:  state_d = ST_EDGE;
      ST_EDGE: state_d = ST_XMUL;
      ST_XMUL: begin
        if (cnt_q == CntW'(6)) state_d = ST_SQMUL;
      end
      ST_SQMUL: begin
        if (cnt_q == CntW'(9)) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (cnt_q == CntW'(RootSteps)) state_d = ST_LEN;
      end
      ST_LEN:  state_d = (rd_res == '0) ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (cnt_q == CntW'(DivSteps + 1) && comp_q == 2'd2) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    vs_we         = 1'b0;
    vs_raddr      = AddrW'(idx_q[0]);
    mul_a         = '0;
    mul_b         = '0;
    rd_ctl        = '{load: 1'b0, step: 1'b0, mode: RD_SQRT};
    rd_load_rem   = '0;
    rd_src        = s_q[SumW-1:SumW-2];
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        vs_we         = s_fire && (in_cmd == CMD_VERTEX) && in_ok[0];
      end
      ST_RDA: vs_raddr = AddrW'(idx_q[0]);
      ST_RDB: vs_raddr = AddrW'(idx_q[1]);
      ST_RDC: vs_raddr = AddrW'(idx_q[2]);
      ST_XMUL: begin
        case (cnt_q)
          CntW'(0): begin mul_a = MulW'(e1_q[1]); mul_b = MulW'(e2_q[2]); end
          CntW'(1): begin mul_a = MulW'(e1_q[2]); mul_b = MulW'(e2_q[1]); end
          CntW'(2): begin mul_a = MulW'(e1_q[2]); mul_b = MulW'(e2_q[0]); end
          CntW'(3): begin mul_a = MulW'(e1_q[0]); mul_b = MulW'(e2_q[2]); end
          CntW'(4): begin mul_a = MulW'(e1_q[0]); mul_b = MulW'(e2_q[1]); end
          CntW'(5): begin mul_a = MulW'(e1_q[1]); mul_b = MulW'(e2_q[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_SQMUL: begin
        case (part_q)
          PART_HH: begin mul_a = $signed({1'b0, mag_hi}); mul_b = $signed({1'b0, mag_hi}); end
          PART_HL: begin mul_a = $signed({1'b0, mag_hi}); mul_b = $signed({1'b0, mag_lo}); end
          PART_LL: begin mul_a = $signed({1'b0, mag_lo}); mul_b = $signed({1'b0, mag_lo}); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_ROOT: begin
        rd_ctl.mode = RD_SQRT;
        rd_ctl.load = (cnt_q == '0);
        rd_ctl.step = (cnt_q != '0);
      end
      ST_DIV: begin
        rd_ctl.mode = RD_DIV;
        rd_ctl.load = (cnt_q == '0);
        rd_ctl.step = (cnt_q != '0) && (cnt_q <= CntW'(DivSteps));
        rd_load_rem = RemW'(mag_w >> 1);
        rd_src      = (cnt_q == CntW'(1)) ? {1'b0, mag_w[0]} : 2'b00;
      end
      default: begin
        rd_ctl = '{load: 1'b0, step: 1'b0, mode: RD_SQRT};
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      part_q      <= PART_HH;
      part_d1_q   <= PART_HH;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      part_d1_q <= part_q;
      if (state_d != state_q) begin
        cnt_q  <= '0;
        comp_q <= '0;
        part_q <= PART_HH;
      end else if (state_q == ST_DIV && cnt_q == CntW'(DivSteps + 1)) begin
        cnt_q  <= '0;
        comp_q <= comp_q + 2'd1;
      end else begin
        cnt_q <= cnt_q + CntW'(1);
        if (state_q == ST_SQMUL) begin
          if (part_q == PART_LL) begin
            part_q <= PART_HH;
            comp_q <= comp_q + 2'd1;
          end else begin
            part_q <= ffne_part_e'(part_q + 2'd1);
          end
        end
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          for (int i = 0; i < 3; i++) begin
            idx_q[i] <= in_idx[i];
            ok_q[i]  <= in_ok[i];
          end
        end
      end
      ST_RDB: begin
        for (int i = 0; i < 3; i++) pa_q[i] <= ok_q[0] ? rd_pos[i] : '0;
      end
      ST_RDC: begin
        for (int i = 0; i < 3; i++) pb_q[i] <= ok_q[1] ? rd_pos[i] : '0;
      end
      ST_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= EdgeW'(pb_q[i]) - EdgeW'(pa_q[i]);
          e2_q[i] <= (ok_q[2] ? EdgeW'(rd_pos[i]) : EdgeW'(0)) - EdgeW'(pa_q[i]);
        end
        s_q <= '0;
      end
      ST_XMUL: begin
        if (cnt_q != '0) begin
          if (xidx[0] == 1'b0) begin
            cr_q[xidx[2:1]] <= CrossW'(mul_p);
          end else begin
            cr_q[xidx[2:1]] <= cr_q[xidx[2:1]] - CrossW'(mul_p);
          end
        end
      end
      ST_SQMUL: begin
        if (cnt_q != '0) s_q <= s_q + sq_term;
      end
      ST_ROOT: begin
        if (cnt_q != '0) s_q <= {s_q[SumW-3:0], 2'b00};
      end
      ST_LEN: begin
        len_q <= rd_res;
        deg_q <= (rd_res == '0);
        for (int i = 0; i < 3; i++) norm_q[i] <= '0;
      end
      ST_DIV: begin
        if (cnt_q == CntW'(DivSteps + 1)) begin
          norm_q[comp_q] <= cr_sel[CrossW-1] ? (NormW'(0) - quot_ext) : quot_ext;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_q <= {2'b00, idx_q[2], idx_q[1], idx_q[0], norm_q[2], norm_q[1], norm_q[0]};
          out_user_q <= deg_q;
        end
      end
      default: begin
      end
    endcase
  end

  ffne_vstore #(
    .DEPTH (VERTEX_DEPTH),
    .AW    (AddrW)
  ) u_vstore (
    .clk_i   (clk_i),
    .we_i    (vs_we),
    .waddr_i (AddrW'(in_idx[0])),
    .wdata_i (in_pos),
    .raddr_i (vs_raddr),
    .rdata_o (vs_rdata)
  );

  ffne_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ffne_rdunit u_rdunit (
    .clk_i      (clk_i),
    .ctl_i      (rd_ctl),
    .load_rem_i (rd_load_rem),
    .src_i      (rd_src),
    .divisor_i  (len_q),
    .res_o      (rd_res)
  );

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_user_q;

  `FFNE_ASSERT_IMPL(a_deg_zero, m_axis_tvalid && m_axis_tuser[0],
    m_axis_tdata[47:0] == '0, "degenerate result with nonzero normal")
  `FFNE_ASSERT_IMPL(a_norm_range, m_axis_tvalid,
    ($signed(m_axis_tdata[15:0]) >= -16'sd16384) &&
    ($signed(m_axis_tdata[15:0]) <= 16'sd16384) &&
    ($signed(m_axis_tdata[31:16]) >= -16'sd16384) &&
    ($signed(m_axis_tdata[31:16]) <= 16'sd16384) &&
    ($signed(m_axis_tdata[47:32]) >= -16'sd16384) &&
    ($signed(m_axis_tdata[47:32]) <= 16'sd16384), "normal component out of range")
  `FFNE_ASSERT_IMPL(a_div_len, state_q == ST_DIV, len_q != '0,
    "division entered with zero length")
  `FFNE_ASSERT_NEXT(a_done_load, (state_q == ST_DONE) && (!m_axis_tvalid || m_axis_tready),
    m_axis_tvalid && (state_q == ST_IDLE), "finished result not loaded into output register")

endmodule

/* verif/tb_flat_face_normal_engine_core.sv */
// Testbench of the flat face normal engine core: random vertex/triangle stream, scoreboard.
`timescale 1ns / 1ps
module tb_flat_face_normal_engine_core;
  import ffne_pkg::*;

  localparam int DEPTH      = VertexDepthDef;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 700;
  localparam int TAIL_WAIT  = 150;

  localparam int RX_OPEN     = 0;
  localparam int RX_LIGHT    = 1;
  localparam int RX_HEAVY    = 2;
  localparam int RX_PERIODIC = 3;

  typedef struct {
    ffne_cmd_e         cmd;
    logic [IdxW-1:0]   ia;
    logic [IdxW-1:0]   ib;
    logic [IdxW-1:0]   ic;
    logic [PosW-1:0]   px;
    logic [PosW-1:0]   py;
    logic [PosW-1:0]   pz;
  } geom_item_t;

  typedef struct packed {
    logic signed [NormW-1:0] nx;
    logic signed [NormW-1:0] ny;
    logic signed [NormW-1:0] nz;
    logic                    degen;
    logic [IdxW-1:0]         ca;
    logic [IdxW-1:0]         cb;
    logic [IdxW-1:0]         cc;
  } face_t;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             s_valid = 1'b0;
  logic [DataW-1:0] s_data = '0;
  logic [0:0]       s_user = '0;
  logic             m_ready = 1'b0;
  logic             s_axis_tready;
  logic             m_axis_tvalid;
  logic [DataW-1:0] m_axis_tdata;
  logic [0:0]       m_axis_tuser;

  geom_item_t geom_q[$];
  face_t      normal_q[$];
  geom_item_t cur_item;

  logic signed [PosW-1:0] vtx_x [DEPTH];
  logic signed [PosW-1:0] vtx_y [DEPTH];
  logic signed [PosW-1:0] vtx_z [DEPTH];

  bit  was_written [DEPTH];
  int  written_list[$];
  int  errors = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  rx_mode = RX_OPEN;
  int  rx_left = 0;
  int  rx_phase = 0;
  int  idle_cycles = 0;

  flat_face_normal_engine_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [NormW-1:0] unit_comp(longint c, longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    q = (mag * UnitVal) / len;
    if (q > UnitVal) q = UnitVal;
    return (c < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic face_t face_normal(logic [IdxW-1:0] ia, logic [IdxW-1:0] ib,
                                        logic [IdxW-1:0] ic);
    face_t           res;
    longint          e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
    longint unsigned mx, my, mz, root;
    logic [127:0]    sum_sq, trial;
    e1x = longint'(vtx_x[ib]) - longint'(vtx_x[ia]);
    e1y = longint'(vtx_y[ib]) - longint'(vtx_y[ia]);
    e1z = longint'(vtx_z[ib]) - longint'(vtx_z[ia]);
    e2x = longint'(vtx_x[ic]) - longint'(vtx_x[ia]);
    e2y = longint'(vtx_y[ic]) - longint'(vtx_y[ia]);
    e2z = longint'(vtx_z[ic]) - longint'(vtx_z[ia]);
    cx = e1y * e2z - e1z * e2y;
    cy = e1z * e2x - e1x * e2z;
    cz = e1x * e2y - e1y * e2x;
    mx = (cx < 0) ? longint'(-cx) : longint'(cx);
    my = (cy < 0) ? longint'(-cy) : longint'(cy);
    mz = (cz < 0) ? longint'(-cz) : longint'(cz);
    sum_sq = 128'(mx) * 128'(mx) + 128'(my) * 128'(my) + 128'(mz) * 128'(mz);
    root = 0;
    for (int b = 40; b >= 0; b--) begin
      trial = 128'(root | (64'd1 << b));
      if (trial * trial <= sum_sq) root = root | (64'd1 << b);
    end
    if (root == 0) begin
      res.nx    = '0;
      res.ny    = '0;
      res.nz    = '0;
      res.degen = 1'b1;
    end else begin
      res.nx    = unit_comp(cx, root);
      res.ny    = unit_comp(cy, root);
      res.nz    = unit_comp(cz, root);
      res.degen = 1'b0;
    end
    res.ca = ia;
    res.cb = ib;
    res.cc = ic;
    return res;
  endfunction

  task automatic push_vertex(int idx, logic [PosW-1:0] x, logic [PosW-1:0] y,
                             logic [PosW-1:0] z);
    geom_item_t it;
    it.cmd = CMD_VERTEX;
    it.ia  = IdxW'(idx);
    it.ib  = IdxW'($urandom);
    it.ic  = IdxW'($urandom);
    it.px  = x;
    it.py  = y;
    it.pz  = z;
    geom_q.push_back(it);
    if (!was_written[idx]) written_list.push_back(idx);
    was_written[idx] = 1'b1;
  endtask

  task automatic push_triangle(int a, int b, int c);
    geom_item_t it;
    it.cmd = CMD_TRIANGLE;
    it.ia  = IdxW'(a);
    it.ib  = IdxW'(b);
    it.ic  = IdxW'(c);
    it.px  = PosW'($urandom);
    it.py  = PosW'($urandom);
    it.pz  = PosW'($urandom);
    geom_q.push_back(it);
  endtask

  function automatic logic [PosW-1:0] rand_pos();
    case ($urandom_range(0, 2))
      0:       return PosW'($urandom);
      1:       return PosW'($urandom_range(0, 1023) - 512);
      default: return PosW'($urandom_range(0, 127) - 64);
    endcase
  endfunction

  function automatic int pick_corner();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    logic take;
    take = s_valid && s_axis_tready;
    if (take) begin
      if (cur_item.cmd == CMD_VERTEX) begin
        vtx_x[cur_item.ia] = cur_item.px;
        vtx_y[cur_item.ia] = cur_item.py;
        vtx_z[cur_item.ia] = cur_item.pz;
      end else begin
        normal_q.push_back(face_normal(cur_item.ia, cur_item.ib, cur_item.ic));
      end
    end
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || take) begin
      if (gap_left > 0) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (geom_q.size() > 0) begin
        cur_item = geom_q.pop_front();
        s_valid <= 1'b1;
        s_data  <= {2'b00, cur_item.pz, cur_item.py, cur_item.px,
                    cur_item.ic, cur_item.ib, cur_item.ia};
        s_user  <= cur_item.cmd;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each transaction with the oldest expected normal, and drive m_ready in random patterns.
  always @(posedge clk_i) begin
    face_t want;
    logic  rdy;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      if (normal_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = normal_q.pop_front();
        check_field("normal_x", want.nx, m_axis_tdata[15:0]);
        check_field("normal_y", want.ny, m_axis_tdata[31:16]);
        check_field("normal_z", want.nz, m_axis_tdata[47:32]);
        check_field("corner_a", 16'(want.ca), 16'(m_axis_tdata[57:48]));
        check_field("corner_b", 16'(want.cb), 16'(m_axis_tdata[67:58]));
        check_field("corner_c", 16'(want.cc), 16'(m_axis_tdata[77:68]));
        check_field("degenerate", 16'(want.degen), 16'(m_axis_tuser[0]));
      end
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(RX_OPEN, RX_PERIODIC);
      rx_left = $urandom_range(32, 256);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      RX_OPEN:  rdy = 1'b1;
      RX_LIGHT: rdy = ($urandom_range(0, 3) != 0);
      RX_HEAVY: rdy = ($urandom_range(0, 3) == 0);
      default:  rdy = ((rx_phase % 7) < 3);
    endcase
    m_ready <= rdy;
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int count;
    int a, b, c, base_x, base_y, base_z, dx, dy, dz;

    // corners of a cube at the extremes of the coordinate range
    push_vertex(0,    16'h8000, 16'h8000, 16'h8000);
    push_vertex(1023, 16'h7fff, 16'h8000, 16'h8000);
    push_vertex(512,  16'h8000, 16'h7fff, 16'h8000);
    push_vertex(341,  16'h8000, 16'h8000, 16'h7fff);
    push_triangle(0, 1023, 512);
    push_triangle(0, 512, 1023);
    push_triangle(0, 1023, 341);
    push_triangle(0, 512, 341);
    push_triangle(1023, 512, 341);
    // zero-area faces: repeated corners, then collinear corners
    push_triangle(0, 0, 0);
    push_triangle(512, 512, 341);
    push_vertex(2, 16'h0100, 16'h0100, 16'h0100);
    push_vertex(3, 16'h0200, 16'h0200, 16'h0200);
    push_vertex(4, 16'h0300, 16'h0300, 16'h0300);
    push_triangle(2, 3, 4);
    push_vertex(5, 16'h7fff, 16'h7fff, 16'h7fff);
    push_triangle(0, 5, 1023);
    push_triangle(341, 5, 512);

    count = 0;
    while (count < RAND_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          // collinear triple followed by its triangle
          a = $urandom_range(0, 1023);
          b = $urandom_range(0, 1023);
          c = $urandom_range(0, 1023);
          base_x = $urandom_range(0, 8191) - 4096;
          base_y = $urandom_range(0, 8191) - 4096;
          base_z = $urandom_range(0, 8191) - 4096;
          dx = $urandom_range(0, 4095) - 2048;
          dy = $urandom_range(0, 4095) - 2048;
          dz = $urandom_range(0, 4095) - 2048;
          push_vertex(a, 16'(base_x), 16'(base_y), 16'(base_z));
          push_vertex(b, 16'(base_x + dx), 16'(base_y + dy), 16'(base_z + dz));
          push_vertex(c, 16'(base_x + 2 * dx), 16'(base_y + 2 * dy), 16'(base_z + 2 * dz));
          push_triangle(a, b, c);
          count += 4;
        end
        2, 3, 4, 5, 6, 7, 8, 9: begin
          a = ($urandom_range(0, 9) < 4) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
          push_vertex(a, rand_pos(), rand_pos(), rand_pos());
          count++;
        end
        default: begin
          a = pick_corner();
          b = pick_corner();
          c = pick_corner();
          case ($urandom_range(0, 19))
            0:       b = a;
            1:       c = b;
            2:       c = a;
            default: ;
          endcase
          push_triangle(a, b, c);
          count++;
        end
      endcase
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (geom_q.size() != 0 || s_valid || normal_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ffne_pkg.sv
rtl/core/ffne_vstore.sv
rtl/core/ffne_mul.sv
rtl/core/ffne_rdunit.sv
rtl/core/flat_face_normal_engine_core.sv
verif/tb_flat_face_normal_engine_core.sv
